// ===== rtl/core/arpc_pkg.sv =====
// arpc_pkg: shared types and constants for the arp responder with cache
// used by arpc_cell and arp_responder_with_cache; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 264;

    localparam logic [15:0] MIN_MSG_LEN = 16'd28;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN = 8'd6;
    localparam logic [7:0]  IP_ADDR_LEN = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;
    localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

    // outgoing arp operation field
    localparam logic [1:0] FOP_REQUEST = 2'd1;
    localparam logic [1:0] FOP_REPLY   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_MAC     = 2'd2;

    // input selector
    localparam logic FUNC_MSG   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_LOCAL_MAC = 1'b0;
    localparam logic CFG_LOCAL_IP  = 1'b1;

    // lookup token moving down the cell row
    typedef struct packed {
        logic        act;
        logic [31:0] key;
        logic        hit;
        logic [47:0] mac;
    } t_srch;

    // write command broadcast to the cells
    typedef struct packed {
        logic        upd;
        logic        ins;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_wr;

endpackage

`default_nettype wire

// ===== rtl/core/arp_responder_with_cache.sv =====
// arp_responder_with_cache: arp responder over a row of arpc_cell cache entries (arpc_pkg)
// path: a reply frame is registered in r_res_data, then in the output register once it is free;
// a query token first walks down the cell row, then its result takes the same path
// throughput: one item at a time, tready only while idle; the next item is taken once the last
// is dropped, handed to the output register or issued as a cache write, later on output stalls
// reset: synchronous, clears cache valid bits, victim pointer, local mac and ip
`timescale 1ns / 1ps
`default_nettype none

module arp_responder_with_cache #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write port
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_addr,
    input  wire logic [47:0]                   i_cfg_wdata,
    // input items
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // frame_length, hw_type, proto_type, hw_len, proto_len, opcode,
    // sender_mac, sender_ip, target_ip, query_ip
    input  wire logic [arpc_pkg::IN_DATA_W-1:0] i_s_tdata,
    // func
    input  wire logic                          i_s_tuser,
    // result items
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // frame_dest_mac, frame_opcode, frame_sender_mac, frame_sender_ip,
    // frame_target_mac, frame_target_ip, resolved_mac, zero pad
    output logic [arpc_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // out_kind
    output logic [1:0]                         o_m_tuser
);
    import arpc_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [47:0]           r_local_mac;
    logic [31:0]           r_local_ip;
    logic [IDX_W-1:0]      r_victim;
    logic                  r_is_query;
    logic [31:0]           r_key;
    logic [47:0]           r_mac_in;
    t_srch                 r_srch;
    t_wr                   r_wr;
    logic [IDX_W-1:0]      r_wr_idx;
    logic [1:0]            r_res_kind;
    logic [OUT_DATA_W-1:0] r_res_data;
    logic                  r_out_valid;
    logic [1:0]            r_out_kind;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_srch                 w_link [CACHE_ENTRIES+1];
    t_srch                 w_tail;

    // input fields
    logic [15:0] w_frame_length, w_hw_type, w_proto_type, w_opcode;
    logic [7:0]  w_hw_len, w_proto_len;
    logic [47:0] w_sender_mac;
    logic [31:0] w_sender_ip, w_target_ip, w_query_ip;
    logic        w_msg_ok;
    logic [OUT_DATA_W-1:0] w_reply_data, w_req_data, w_mac_data;
    logic        w_out_free;

    assign w_frame_length = i_s_tdata[15:0];
    assign w_hw_type      = i_s_tdata[31:16];
    assign w_proto_type   = i_s_tdata[47:32];
    assign w_hw_len       = i_s_tdata[55:48];
    assign w_proto_len    = i_s_tdata[63:56];
    assign w_opcode       = i_s_tdata[79:64];
    assign w_sender_mac   = i_s_tdata[127:80];
    assign w_sender_ip    = i_s_tdata[159:128];
    assign w_target_ip    = i_s_tdata[191:160];
    assign w_query_ip     = i_s_tdata[223:192];

    assign w_msg_ok = (w_frame_length >= MIN_MSG_LEN) && (w_hw_type == HW_ETHERNET)
                   && (w_proto_type == PROTO_IPV4) && (w_hw_len == HW_ADDR_LEN)
                   && (w_proto_len == IP_ADDR_LEN) && (w_target_ip == r_local_ip);

    assign w_reply_data = {6'd0, 48'd0, w_sender_ip, w_sender_mac, r_local_ip,
                           r_local_mac, FOP_REPLY, w_sender_mac};
    assign w_req_data   = {6'd0, 48'd0, r_key, BCAST_MAC, r_local_ip,
                           r_local_mac, FOP_REQUEST, BCAST_MAC};
    assign w_mac_data   = {6'd0, w_tail.mac, 32'd0, 48'd0, 32'd0, 48'd0, 2'd0, 48'd0};

    assign w_out_free = !r_out_valid || i_m_tready;

    // cell row
    assign w_link[0] = r_srch;
    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        t_wr w_cell_wr;
        always_comb begin
            w_cell_wr     = r_wr;
            w_cell_wr.ins = r_wr.ins && (r_wr_idx == IDX_W'(g));
        end
        arpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_srch  (w_link[g]),
            .o_srch  (w_link[g+1]),
            .i_wr    (w_cell_wr)
        );
    end
    assign w_tail = w_link[CACHE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_local_mac <= '0;
            r_local_ip  <= '0;
            r_victim    <= '0;
            r_is_query  <= 1'b0;
            r_srch      <= '0;
            r_wr        <= '0;
            r_wr_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_LOCAL_MAC: r_local_mac <= i_cfg_wdata;
                    CFG_LOCAL_IP:  r_local_ip  <= i_cfg_wdata[31:0];
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    r_wr.upd <= 1'b0;
                    r_wr.ins <= 1'b0;
                    if (i_s_tvalid) begin
                        if (i_s_tuser == FUNC_QUERY) begin
                            r_srch     <= '{act: 1'b1, key: w_query_ip, hit: 1'b0, mac: '0};
                            r_is_query <= 1'b1;
                            r_key      <= w_query_ip;
                            r_state    <= S_SCAN;
                        end else if (w_msg_ok && (w_opcode == OP_REQUEST)) begin
                            r_res_kind <= KIND_REPLY;
                            r_res_data <= w_reply_data;
                            r_state    <= S_EMIT;
                        end else if (w_msg_ok && (w_opcode == OP_REPLY)) begin
                            r_srch     <= '{act: 1'b1, key: w_sender_ip, hit: 1'b0, mac: '0};
                            r_is_query <= 1'b0;
                            r_key      <= w_sender_ip;
                            r_mac_in   <= w_sender_mac;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_srch.act <= 1'b0;
                    if (w_tail.act) begin
                        if (r_is_query) begin
                            r_res_kind <= w_tail.hit ? KIND_MAC : KIND_REQUEST;
                            r_res_data <= w_tail.hit ? w_mac_data : w_req_data;
                            r_state    <= S_EMIT;
                        end else begin
                            r_wr     <= '{upd: w_tail.hit, ins: !w_tail.hit,
                                          ip: r_key, mac: r_mac_in};
                            r_wr_idx <= r_victim;
                            if (!w_tail.hit) begin
                                r_victim <= (r_victim == IDX_W'(CACHE_ENTRIES - 1)) ?
                                            '0 : r_victim + 1'b1;
                            end
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_res_kind;
                        r_out_data  <= r_res_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

    // token leaves the row only while a lookup is pending
    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.act |-> (r_state == S_SCAN))
        else $error("lookup token left the cell row outside a scan");

    a_wr_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr.upd && r_wr.ins))
        else $error("cache update and insert issued together");

    a_wr_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr.upd || r_wr.ins) |-> ($past(r_state) == S_SCAN && r_state == S_IDLE))
        else $error("cache write not issued at the end of a scan");

    a_emit_from_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_tail.act && r_is_query) |=> (r_state == S_EMIT))
        else $error("query lookup did not produce a result");

endmodule

`default_nettype wire

// ===== rtl/core/arpc_cell.sv =====
// arpc_cell: one cache entry, compares the passing lookup token and forwards it
// depends on arpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module arpc_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire arpc_pkg::t_srch i_srch,
    output arpc_pkg::t_srch     o_srch,
    input  wire arpc_pkg::t_wr  i_wr
);
    import arpc_pkg::*;

    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    t_srch       r_srch;
    logic        w_match;

    assign w_match = r_valid && (r_ip == i_srch.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_srch  <= '0;
        end else begin
            r_srch.act <= i_srch.act;
            r_srch.key <= i_srch.key;
            r_srch.hit <= i_srch.hit || w_match;
            r_srch.mac <= i_srch.hit ? i_srch.mac : r_mac;
            if (i_wr.ins) begin
                r_valid <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.ins) begin
            r_ip  <= i_wr.ip;
            r_mac <= i_wr.mac;
        end else if (i_wr.upd && r_valid && (r_ip == i_wr.ip)) begin
            r_mac <= i_wr.mac;
        end
    end

    assign o_srch = r_srch;

endmodule

`default_nettype wire

// ===== verif/tb_arp_responder_with_cache.sv =====
// tb_arp_responder_with_cache: self-checking bench for the arp responder with address cache
// depends on arpc_pkg and arp_responder_with_cache; tracks cache contents to predict each
// reply frame, broadcast request and resolved mac
`timescale 1ns / 1ps

module tb_arp_responder_with_cache;
    import arpc_pkg::*;

    localparam int CACHE_DEPTH = 16;
    // a cache update walks the whole cell row and gives no result item
    localparam int SETTLE      = 2 * (CACHE_DEPTH + 3) + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 24;

    // fields from the lowest bit up: frame_length .. query_ip
    typedef struct packed {
        logic [31:0] query_ip;
        logic [31:0] target_ip;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [15:0] opcode;
        logic [7:0]  proto_len;
        logic [7:0]  hw_len;
        logic [15:0] proto_type;
        logic [15:0] hw_type;
        logic [15:0] frame_length;
    } arp_msg_t;

    // fields from the lowest bit up: frame_dest_mac .. resolved_mac, zero pad
    typedef struct packed {
        logic [5:0]  pad;
        logic [47:0] resolved_mac;
        logic [31:0] tgt_ip;
        logic [47:0] tgt_mac;
        logic [31:0] snd_ip;
        logic [47:0] snd_mac;
        logic [1:0]  op;
        logic [47:0] dest_mac;
    } arp_frame_t;

    typedef struct {
        logic [1:0] kind;
        arp_frame_t body;
    } arp_result_t;

    class arp_cache_shadow;
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic        valid_q[CACHE_DEPTH];
        logic [31:0] ip_q[CACHE_DEPTH];
        logic [47:0] mac_q[CACHE_DEPTH];
        int          victim;
        arp_result_t due_results[$];
        int          errors;

        function new();
            own_mac = '0;
            own_ip  = '0;
            victim  = 0;
            errors  = 0;
            foreach (valid_q[i]) begin
                valid_q[i] = 1'b0;
                ip_q[i]    = '0;
                mac_q[i]   = '0;
            end
        endfunction

        function int lookup(logic [31:0] ip);
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (valid_q[i] && ip_q[i] == ip) return i;
            end
            return -1;
        endfunction

        function void take_item(arp_msg_t m, logic fn);
            arp_result_t r;
            int          hit;
            r.body = '0;
            if (fn == FUNC_QUERY) begin
                hit = lookup(m.query_ip);
                if (hit >= 0) begin
                    r.kind              = KIND_MAC;
                    r.body.resolved_mac = mac_q[hit];
                end else begin
                    r.kind          = KIND_REQUEST;
                    r.body.dest_mac = BCAST_MAC;
                    r.body.op       = FOP_REQUEST;
                    r.body.snd_mac  = own_mac;
                    r.body.snd_ip   = own_ip;
                    r.body.tgt_mac  = BCAST_MAC;
                    r.body.tgt_ip   = m.query_ip;
                end
                due_results.push_back(r);
                return;
            end
            if (m.frame_length < MIN_MSG_LEN) return;
            if (m.hw_type != HW_ETHERNET || m.proto_type != PROTO_IPV4 ||
                m.hw_len != HW_ADDR_LEN || m.proto_len != IP_ADDR_LEN ||
                m.target_ip != own_ip) return;
            if (m.opcode == OP_REQUEST) begin
                r.kind          = KIND_REPLY;
                r.body.dest_mac = m.sender_mac;
                r.body.op       = FOP_REPLY;
                r.body.snd_mac  = own_mac;
                r.body.snd_ip   = own_ip;
                r.body.tgt_mac  = m.sender_mac;
                r.body.tgt_ip   = m.sender_ip;
                due_results.push_back(r);
            end else if (m.opcode == OP_REPLY) begin
                hit = lookup(m.sender_ip);
                if (hit >= 0) begin
                    mac_q[hit] = m.sender_mac;
                end else begin
                    valid_q[victim] = 1'b1;
                    ip_q[victim]    = m.sender_ip;
                    mac_q[victim]   = m.sender_mac;
                    victim          = (victim + 1) % CACHE_DEPTH;
                end
            end
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_result(logic [1:0] kind, arp_frame_t f);
            arp_result_t e;
            if (due_results.size() == 0) begin
                flag("out_kind of unexpected item", '0, kind);
                return;
            end
            e = due_results.pop_front();
            if (kind !== e.kind) flag("out_kind", e.kind, kind);
            if (f.dest_mac !== e.body.dest_mac) flag("frame_dest_mac", e.body.dest_mac, f.dest_mac);
            if (f.op !== e.body.op) flag("frame_opcode", e.body.op, f.op);
            if (f.snd_mac !== e.body.snd_mac) flag("frame_sender_mac", e.body.snd_mac, f.snd_mac);
            if (f.snd_ip !== e.body.snd_ip) flag("frame_sender_ip", e.body.snd_ip, f.snd_ip);
            if (f.tgt_mac !== e.body.tgt_mac) flag("frame_target_mac", e.body.tgt_mac, f.tgt_mac);
            if (f.tgt_ip !== e.body.tgt_ip) flag("frame_target_ip", e.body.tgt_ip, f.tgt_ip);
            if (f.resolved_mac !== e.body.resolved_mac)
                flag("resolved_mac", e.body.resolved_mac, f.resolved_mac);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_addr;
    logic [47:0]           i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // frame_length .. query_ip
    logic                  i_s_tuser;   // func
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // frame_dest_mac .. resolved_mac, zero pad
    logic [1:0]            o_m_tuser;   // out_kind

    arp_cache_shadow sb;
    logic            steady = 1'b0;
    logic [31:0]     known_ips[POOL_SIZE];
    int unsigned     cycles;

    arp_responder_with_cache #(
        .CACHE_ENTRIES(CACHE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // result side: check what was taken at this edge, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, arp_frame_t'(o_m_tdata));
        i_m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [47:0] pick_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return BCAST_MAC;
            default: return w[47:0];
        endcase
    endfunction

    function automatic arp_msg_t noise();
        return arp_msg_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom()});
    endfunction

    // well formed message aimed at us, query_ip left as noise
    function automatic arp_msg_t good_msg(logic [15:0] op, logic [47:0] smac, logic [31:0] sip);
        arp_msg_t m;
        m              = noise();
        m.frame_length = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(28, 65535))
                                                     : 16'(28 + $urandom_range(0, 40));
        m.hw_type      = HW_ETHERNET;
        m.proto_type   = PROTO_IPV4;
        m.hw_len       = HW_ADDR_LEN;
        m.proto_len    = IP_ADDR_LEN;
        m.opcode       = op;
        m.sender_mac   = smac;
        m.sender_ip    = sip;
        m.target_ip    = sb.own_ip;
        return m;
    endfunction

    task automatic push_item(input arp_msg_t m, input logic fn);
        while (!steady && $urandom_range(0, 99) < 28) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= m;
        i_s_tuser  <= fn;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.take_item(m, fn);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
    endtask

    // both registers, written only with the block idle
    task automatic set_identity(input logic [47:0] mac, input logic [31:0] ip);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_LOCAL_MAC;
        i_cfg_wdata <= mac;
        @(posedge i_clk);
        sb.own_mac  = mac;
        i_cfg_addr  <= CFG_LOCAL_IP;
        i_cfg_wdata <= {16'h0, ip};
        @(posedge i_clk);
        sb.own_ip   = ip;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        arp_msg_t    m;
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        ip_a = known_ips[2];
        ip_b = known_ips[3];

        m = '1; m.query_ip = ip_a;
        push_item(m, FUNC_QUERY);                         // empty cache, broadcast request
        m = good_msg(OP_REQUEST, BCAST_MAC, '1); m.frame_length = MIN_MSG_LEN;
        push_item(m, FUNC_MSG);
        m.frame_length = MIN_MSG_LEN - 1;                 // one byte short
        push_item(m, FUNC_MSG);
        m = good_msg(OP_REQUEST, '0, '0); m.frame_length = '1;
        push_item(m, FUNC_MSG);
        m.frame_length = '0;
        push_item(m, FUNC_MSG);
        m = good_msg(OP_REQUEST, pick_mac(), $urandom()); m.hw_type = '0;
        push_item(m, FUNC_MSG);
        m.hw_type = '1;
        push_item(m, FUNC_MSG);
        m.hw_type = HW_ETHERNET; m.proto_type = 16'h0008; // byte-swapped ipv4 type
        push_item(m, FUNC_MSG);
        m.proto_type = PROTO_IPV4; m.hw_len = '0;
        push_item(m, FUNC_MSG);
        m.hw_len = '1;
        push_item(m, FUNC_MSG);
        m.hw_len = HW_ADDR_LEN; m.proto_len = '1;
        push_item(m, FUNC_MSG);
        m.proto_len = IP_ADDR_LEN; m.target_ip = ~sb.own_ip;
        push_item(m, FUNC_MSG);
        m.target_ip = sb.own_ip; m.opcode = 16'h0000;     // unknown operations
        push_item(m, FUNC_MSG);
        m.opcode = 16'h0003;
        push_item(m, FUNC_MSG);
        m.opcode = 16'hFFFF;
        push_item(m, FUNC_MSG);
        m.opcode = 16'h0100;
        push_item(m, FUNC_MSG);
        // zero mac in the cache must still hit, then gets overwritten
        push_item(good_msg(OP_REPLY, '0, ip_a), FUNC_MSG);
        m = noise(); m.query_ip = ip_a;
        push_item(m, FUNC_QUERY);
        push_item(good_msg(OP_REPLY, BCAST_MAC, ip_a), FUNC_MSG);
        m = '0; m.query_ip = ip_a;
        push_item(m, FUNC_QUERY);
        m = good_msg(OP_REPLY, pick_mac(), ip_b); m.frame_length = 16'd5;
        push_item(m, FUNC_MSG);
        m.frame_length = MIN_MSG_LEN; m.target_ip = sb.own_ip ^ 32'h1;
        push_item(m, FUNC_MSG);
        m = noise(); m.query_ip = ip_b;
        push_item(m, FUNC_QUERY);
    endtask

    // every item counts toward n, noise and malformed ones too
    task automatic run_random(input int n);
        arp_msg_t m;
        int       done;
        int       r;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                m = noise();
                if ($urandom_range(0, 3) != 0) m.query_ip = known_ips[$urandom_range(0, POOL_SIZE-1)];
                push_item(m, FUNC_QUERY);
            end else if (r < 60) begin
                push_item(good_msg(OP_REPLY, pick_mac(),
                                   known_ips[$urandom_range(0, POOL_SIZE-1)]), FUNC_MSG);
            end else if (r < 80) begin
                push_item(good_msg(OP_REQUEST, pick_mac(), $urandom()), FUNC_MSG);
            end else if (r < 88) begin
                m = noise();
                push_item(m, 1'($urandom_range(0, 1)));
            end else begin
                m = good_msg($urandom_range(0, 1) ? OP_REPLY : OP_REQUEST, pick_mac(),
                             known_ips[$urandom_range(0, POOL_SIZE-1)]);
                case ($urandom_range(0, 6))
                    0: m.frame_length = 16'($urandom_range(0, 27));
                    1: m.hw_type      ^= 16'($urandom_range(1, 65535));
                    2: m.proto_type   ^= 16'($urandom_range(1, 65535));
                    3: m.hw_len       ^= 8'($urandom_range(1, 255));
                    4: m.proto_len    ^= 8'($urandom_range(1, 255));
                    5: m.target_ip    ^= 32'($urandom_range(1, 32'hFFFF_FFFF));
                    default: m.opcode  = 16'($urandom_range(3, 65535));
                endcase
                push_item(m, FUNC_MSG);
            end
            done++;
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= CFG_LOCAL_MAC;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= FUNC_MSG;
        foreach (known_ips[i]) known_ips[i] = $urandom();
        known_ips[0] = '0;
        known_ips[1] = '1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs on the reset values of both registers
        run_directed();
        set_identity(BCAST_MAC, '1);
        run_random(300);
        set_identity(pick_mac(), $urandom());
        run_random(250);
        steady = 1'b1;
        run_random(150);
        steady = 1'b0;
        drain();
        run_random(100);
        set_identity('0, '0);
        run_random(450);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== arp_responder_with_cache.f =====
rtl/core/arpc_pkg.sv
rtl/core/arpc_cell.sv
rtl/core/arp_responder_with_cache.sv
verif/tb_arp_responder_with_cache.sv
